@@ hdl/run_length_byte_encoder_core_assert.svh @@
// Assertion macros for the encoder checker.
`ifndef RUN_LENGTH_BYTE_ENCODER_CORE_ASSERT_SVH
`define RUN_LENGTH_BYTE_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RLBE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RLBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/rlbe_pkg.sv @@
// Shared constants for the run-length byte encoder.
package rlbe_pkg;

  localparam int unsigned SYM_W    = 8;
  localparam int unsigned MAX_RUN  = 128;
  localparam int unsigned LEN_W    = $clog2(MAX_RUN + 1);
  localparam int unsigned ADDR_W   = $clog2(MAX_RUN);
  localparam int unsigned TAIL_MAX = 5;
  localparam int unsigned TAIL_W   = $clog2(TAIL_MAX + 1);
  localparam int unsigned TPOS_W   = $clog2(TAIL_MAX);
  // bytes of one transaction: literal header + MAX_RUN literals + tail
  localparam int unsigned IDX_W    = $clog2(MAX_RUN + 1 + TAIL_MAX);
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned OUT_W    = 40;

  localparam logic [SYM_W-1:0] EOD_BYTE     = 8'd128;
  localparam logic [SYM_W-1:0] LIT_ONE_HDR  = 8'd0;
  // 257 - r taken mod 256
  localparam logic [SYM_W-1:0] REP_BASE     = 8'd1;

  typedef logic [TAIL_MAX-1:0][SYM_W-1:0] tail_t;
  typedef logic [3:0][SYM_W-1:0]          word_t;

endpackage

@@ hdl/rlbe_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module rlbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/run_length_byte_encoder_core.sv @@
// Run-length byte encoder top level: decode, literal RAM, byte sequencer, packer.
// A symbol that emits k bytes is taken while the sequencer is idle; then one byte per cycle
//   leaves the sequencer, unless a full word waits for the output slot to free.
// No new symbol is taken until the last byte is out (k up to 132 on a full literal flush
//   at stream end); a symbol that emits nothing leaves the encoder idle for the next one.
// Reset (rst, synchronous, active high) clears run state, sequencer and output valid;
//   the literal RAM is not cleared, as entries are always written before being read.
module run_length_byte_encoder_core (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] symbol
  input  logic        s_tlast,   // final_symbol
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] packed_bytes, [34:32] byte_count, [39:35] zero
  output logic        m_tlast,   // burst_end
  output logic        m_tuser    // stream_done
);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  localparam int unsigned SW = rlbe_pkg::SYM_W;
  localparam int unsigned LW = rlbe_pkg::LEN_W;
  localparam int unsigned AW = rlbe_pkg::ADDR_W;
  localparam int unsigned IW = rlbe_pkg::IDX_W;
  localparam int unsigned TW = rlbe_pkg::TAIL_W;

  // ---------------------------------------------------------------------------
  // Run state
  // ---------------------------------------------------------------------------
  state_t           state;
  logic [SW-1:0]    held_symbol;
  logic             held_valid;
  logic [LW-1:0]    run_length;
  logic             run_is_repeat;

  // Per-transaction byte program, latched on accept
  logic [LW-1:0]    lit_n;       // literals to flush (0 = none)
  logic [IW-1:0]    lit_len;     // header + literals
  rlbe_pkg::tail_t  tail;        // fixed bytes after the literal run
  logic [IW-1:0]    last_idx;
  logic             fin;
  logic [IW-1:0]    idx;

  // Packer
  logic [2:0][SW-1:0] acc;
  logic [1:0]         cnt;

  wire in_acc = s_tvalid && s_tready;
  wire [SW-1:0] sym = s_tdata;

  assign s_tready = (state == ST_IDLE);

  // ---------------------------------------------------------------------------
  // Decode of one symbol: next run state and the bytes it releases
  // ---------------------------------------------------------------------------
  logic [SW-1:0]   held_symbol_next;
  logic            held_valid_next;
  logic [LW-1:0]   run_length_next;
  logic            run_is_repeat_next;
  logic [LW-1:0]   d_lit_n;
  rlbe_pkg::tail_t d_tail;
  logic [TW-1:0]   d_tail_n;
  logic [IW-1:0]   d_lit_len;
  logic [IW-1:0]   d_total;
  logic [LW-1:0]   len_inc;
  logic            ram_wr_en;

  always_comb begin
    held_symbol_next   = held_symbol;
    held_valid_next    = held_valid;
    run_length_next    = run_length;
    run_is_repeat_next = run_is_repeat;
    d_lit_n            = '0;
    d_tail             = '0;
    d_tail_n           = '0;
    ram_wr_en          = 1'b0;
    len_inc            = run_length + LW'(1);

    if (!held_valid) begin
      // stream start: only hold the symbol
      held_symbol_next   = sym;
      held_valid_next    = 1'b1;
      run_length_next    = '0;
      run_is_repeat_next = 1'b0;
    end else if (run_is_repeat) begin
      if (sym == held_symbol && run_length < LW'(rlbe_pkg::MAX_RUN)) begin
        run_length_next = len_inc;
      end else begin
        // run broken or full: emit it, start over with this symbol
        d_tail[0]          = rlbe_pkg::REP_BASE - run_length[SW-1:0];
        d_tail[1]          = held_symbol;
        d_tail_n           = TW'(2);
        held_symbol_next   = sym;
        run_length_next    = '0;
        run_is_repeat_next = 1'b0;
      end
    end else if (sym == held_symbol) begin
      // equal pair closes the literal run and opens a repeat
      d_lit_n            = run_length;
      run_is_repeat_next = 1'b1;
      run_length_next    = LW'(2);
    end else begin
      // held symbol joins the literal run
      ram_wr_en        = 1'b1;
      held_symbol_next = sym;
      if (len_inc == LW'(rlbe_pkg::MAX_RUN)) begin
        d_lit_n         = len_inc;
        run_length_next = '0;
      end else begin
        run_length_next = len_inc;
      end
    end

    if (s_tlast) begin
      if (run_is_repeat_next) begin
        d_tail[d_tail_n[rlbe_pkg::TPOS_W-1:0]] =
          rlbe_pkg::REP_BASE - run_length_next[SW-1:0];
        d_tail_n = d_tail_n + TW'(1);
      end else begin
        if (run_length_next != '0) begin
          d_lit_n = run_length_next;
        end
        // last symbol always goes out as its own literal
        d_tail[d_tail_n[rlbe_pkg::TPOS_W-1:0]] = rlbe_pkg::LIT_ONE_HDR;
        d_tail_n = d_tail_n + TW'(1);
      end
      d_tail[d_tail_n[rlbe_pkg::TPOS_W-1:0]] = held_symbol_next;
      d_tail_n = d_tail_n + TW'(1);
      d_tail[d_tail_n[rlbe_pkg::TPOS_W-1:0]] = rlbe_pkg::EOD_BYTE;
      d_tail_n = d_tail_n + TW'(1);
      held_symbol_next   = '0;
      held_valid_next    = 1'b0;
      run_length_next    = '0;
      run_is_repeat_next = 1'b0;
    end

    d_lit_len = (d_lit_n == '0) ? '0 : IW'(d_lit_n) + IW'(1);
    d_total   = d_lit_len + IW'(d_tail_n);
  end

  // ---------------------------------------------------------------------------
  // Byte sequencer and packer
  // ---------------------------------------------------------------------------
  logic [SW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic [IW-1:0] idx_m1;
  logic [IW-1:0] tail_off;
  logic [SW-1:0] cur_byte;
  logic          is_last;
  logic          word_flush;
  logic          out_free;
  logic          advance;
  rlbe_pkg::word_t wv;

  always_comb begin
    idx_m1   = idx - IW'(1);
    tail_off = idx - lit_len;
    if (idx < lit_len) begin
      cur_byte = (idx == '0) ? (lit_n[SW-1:0] - SW'(1)) : rd_data;
    end else begin
      cur_byte = tail[tail_off[rlbe_pkg::TPOS_W-1:0]];
    end
    is_last    = (idx == last_idx);
    word_flush = (cnt == 2'd3) || is_last;
    out_free   = !m_tvalid || m_tready;
    advance    = (state == ST_RUN) && (!word_flush || out_free);
    // RAM data of the next cycle must match the byte index then in effect
    rd_addr    = advance ? idx[AW-1:0] : idx_m1[AW-1:0];
    wv         = {{SW{1'b0}}, acc};
    wv[cnt]    = cur_byte;
  end

  rlbe_ram #(
    .WIDTH (rlbe_pkg::SYM_W),
    .DEPTH (rlbe_pkg::MAX_RUN)
  ) u_lit_ram (
    .clk     (clk),
    .wr_en   (in_acc && ram_wr_en),
    .wr_addr (run_length[AW-1:0]),
    .wr_data (held_symbol),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      held_symbol   <= '0;
      held_valid    <= 1'b0;
      run_length    <= '0;
      run_is_repeat <= 1'b0;
      idx           <= '0;
      cnt           <= '0;
      acc           <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (in_acc) begin
        held_symbol   <= held_symbol_next;
        held_valid    <= held_valid_next;
        run_length    <= run_length_next;
        run_is_repeat <= run_is_repeat_next;
        lit_n         <= d_lit_n;
        lit_len       <= d_lit_len;
        tail          <= d_tail;
        last_idx      <= d_total - IW'(1);
        fin           <= s_tlast;
        idx           <= '0;
        if (d_total != '0) begin
          state <= ST_RUN;
        end
      end

      if (advance) begin
        idx <= idx + IW'(1);
        if (word_flush) begin
          m_tdata  <= {5'b0, {1'b0, cnt} + 3'd1, wv};
          m_tlast  <= is_last;
          m_tuser  <= is_last && fin;
          acc      <= '0;
          cnt      <= '0;
        end else begin
          acc <= wv[2:0];
          cnt <= cnt + 2'd1;
        end
        if (is_last) begin
          state <= ST_IDLE;
        end
      end

      // a new word takes the output slot; otherwise it empties on a transaction
      if (advance && word_flush) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/rlbe_checker.sv @@
// Port-level checker for the run-length byte encoder, bound to the top level.
`include "run_length_byte_encoder_core_assert.svh"

module rlbe_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  wire [2:0] byte_count = m_tdata[34:32];

  `RLBE_ASSERT_NEXT(a_in_hold, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata) && $stable(s_tlast), "input changed while stalled")
  `RLBE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
  `RLBE_ASSERT_NOW(a_count_range, m_tvalid, byte_count != 3'd0 && byte_count <= 3'd4, "byte count out of range")
  `RLBE_ASSERT_NOW(a_done_is_last, m_tvalid && m_tuser, m_tlast, "end of data not on last result")
  `RLBE_ASSERT_NOW(a_full_word, m_tvalid && !m_tlast, byte_count == 3'd4, "short word before last result")

endmodule

bind run_length_byte_encoder_core rlbe_checker u_rlbe_checker (.*);
